// ===== src/p2c_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants for the scan polar-to-Cartesian converter.
// No dependencies; all other files import this package.
package p2c_pkg;

   localparam int RANGE_W       = 16;
   localparam int INDEX_W       = 11;
   localparam int ANGLE_W       = 16;
   localparam int OUT_W         = 17;
   localparam int CORDIC_STAGES = 16;
   localparam int GAIN_W        = 32;
   localparam int XY_W          = 35;  // covers range * gain * CORDIC growth
   localparam int Z_W           = 21;  // residual angle, 2^20 per turn
   localparam int ROUND_W       = 19;  // rounded x / y before negate
   localparam int MAX_READINGS  = 2048;

   localparam logic [RANGE_W-1:0] GAIN_Q16 = 16'd39797;  // 0.6072529 in Q16

   localparam logic signed [OUT_W-1:0] OUT_MIN = -17'sd65536;
   localparam logic signed [OUT_W-1:0] OUT_MAX = 17'sd65535;

   // round(atan(2^-i) * 2^20 / (2*pi))
   localparam logic signed [Z_W-1:0] ATAN_TABLE [CORDIC_STAGES] = '{
      21'sd131072, 21'sd77376, 21'sd40884, 21'sd20753,
      21'sd10417,  21'sd5213,  21'sd2607,  21'sd1304,
      21'sd652,    21'sd326,   21'sd163,   21'sd81,
      21'sd41,     21'sd20,    21'sd10,    21'sd5
   };

   typedef enum logic {
      CSR_START_ANGLE = 1'b0,
      CSR_ANGLE_STEP  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] start_angle;
      logic [ANGLE_W-1:0] angle_step;
   } angle_cfg_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   negate;
      logic [INDEX_W-1:0]     point_index;
   } cordic_type;

endpackage

// ===== src/p2c_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: reading input, point output, register writes.
// Depends on p2c_pkg.
interface p2c_req_if import p2c_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [RANGE_W-1:0] range_value;
   logic               no_return;
   logic [INDEX_W-1:0] reading_index;

   modport source (output valid, range_value, no_return, reading_index, input ready);
   modport sink   (input valid, range_value, no_return, reading_index, output ready);
endinterface

interface p2c_rsp_if import p2c_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] x_position;
   logic signed [OUT_W-1:0] y_position;
   logic [INDEX_W-1:0]      point_index;

   modport source (output valid, x_position, y_position, point_index, input ready);
   modport sink   (input valid, x_position, y_position, point_index, output ready);
endinterface

interface p2c_csr_if import p2c_pkg::*; ();
   logic               valid;
   logic               ready;
   csr_index_type      reg_index;
   logic [ANGLE_W-1:0] data;

   modport source (output valid, reg_index, data, input ready);
   modport sink   (input valid, reg_index, data, output ready);
endinterface

// ===== src/p2c_angle_prep.sv =====
`timescale 1ns / 1ps
// Front end: index * step and range * gain (stage A), angle sum, quadrant
// fold and CORDIC seed (stage B). Depends on p2c_pkg.
module p2c_angle_prep import p2c_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  angle_cfg_type      cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [RANGE_W-1:0] range_value,
   input  logic               no_return,
   input  logic [INDEX_W-1:0] reading_index,
   output logic               out_valid,
   input  logic               out_ready,
   output cordic_type         out_data
);

   logic               a_valid_ff, a_valid_in;
   logic [INDEX_W-1:0] a_index_ff, a_index_in;
   logic [ANGLE_W-1:0] a_prod_ff, a_prod_in;
   logic [GAIN_W-1:0]  a_gain_ff, a_gain_in;
   logic               b_valid_ff, b_valid_in;
   cordic_type         b_data_ff, b_data_in;

   logic               a_ready, b_ready, keep;
   logic [ANGLE_W-1:0] angle, folded;
   logic               turn;

   assign a_ready  = !a_valid_ff || b_ready;
   assign b_ready  = !b_valid_ff || out_ready;
   assign in_ready = a_ready;

   // no-return readings are taken but leave a bubble; all indices are kept
   assign keep = !no_return && (32'(reading_index) < MAX_READINGS);

   always_comb begin
      a_valid_in = a_valid_ff;
      a_index_in = a_index_ff;
      a_prod_in  = a_prod_ff;
      a_gain_in  = a_gain_ff;
      if (a_ready) begin
         a_valid_in = in_valid && keep;
      end
      if (a_ready && in_valid) begin
         a_index_in = reading_index;
         a_prod_in  = ANGLE_W'(ANGLE_W'(reading_index) * cfg.angle_step);
         a_gain_in  = GAIN_W'(GAIN_W'(range_value) * GAIN_W'(GAIN_Q16));
      end
   end

   // angles in [1/4, 3/4) turn get half a turn added, result negated later
   assign angle  = cfg.start_angle + a_prod_ff;
   assign turn   = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
   assign folded = {angle[ANGLE_W-1] ^ turn, angle[ANGLE_W-2:0]};

   always_comb begin
      b_valid_in = b_valid_ff;
      b_data_in  = b_data_ff;
      if (b_ready) begin
         b_valid_in = a_valid_ff;
      end
      if (b_ready && a_valid_ff) begin
         b_data_in.x           = XY_W'(a_gain_ff);
         b_data_in.y           = '0;
         b_data_in.z           = {folded[ANGLE_W-1], folded, 4'b0000};
         b_data_in.negate      = turn;
         b_data_in.point_index = a_index_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      a_index_ff <= a_index_in;
      a_prod_ff  <= a_prod_in;
      a_gain_ff  <= a_gain_in;
      b_data_ff  <= b_data_in;
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

// ===== src/p2c_cordic_stage.sv =====
`timescale 1ns / 1ps
// One rotation-mode CORDIC iteration with its pipeline register.
// Depends on p2c_pkg (ATAN_TABLE, cordic_type).
module p2c_cordic_stage import p2c_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  cordic_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output cordic_type out_data
);

   logic                   valid_ff, valid_in;
   cordic_type             data_ff, data_in;
   logic signed [XY_W-1:0] x_cur, y_cur, x_sh, y_sh;
   logic signed [Z_W-1:0]  z_cur;

   assign in_ready = !valid_ff || out_ready;

   assign x_cur = in_data.x;
   assign y_cur = in_data.y;
   assign z_cur = in_data.z;
   assign x_sh  = x_cur >>> STAGE;
   assign y_sh  = y_cur >>> STAGE;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
      if (in_ready && in_valid) begin
         data_in = in_data;
         if (!z_cur[Z_W-1]) begin
            data_in.x = x_cur - y_sh;
            data_in.y = y_cur + x_sh;
            data_in.z = z_cur - ATAN_TABLE[STAGE];
         end else begin
            data_in.x = x_cur + y_sh;
            data_in.y = y_cur - x_sh;
            data_in.z = z_cur + ATAN_TABLE[STAGE];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/p2c_finish.sv =====
`timescale 1ns / 1ps
// Back end: round to integer (stage R), negate and saturate into the
// output register (stage O). Depends on p2c_pkg.
module p2c_finish import p2c_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  cordic_type              in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [OUT_W-1:0] x_position,
   output logic signed [OUT_W-1:0] y_position,
   output logic [INDEX_W-1:0]      point_index
);

   localparam logic signed [XY_W-1:0] HALF = XY_W'(32768);

   logic                      r_valid_ff, r_valid_in;
   logic signed [ROUND_W-1:0] r_x_ff, r_x_in, r_y_ff, r_y_in;
   logic                      r_neg_ff, r_neg_in;
   logic [INDEX_W-1:0]        r_index_ff, r_index_in;
   logic                      o_valid_ff, o_valid_in;
   logic signed [OUT_W-1:0]   o_x_ff, o_x_in, o_y_ff, o_y_in;
   logic [INDEX_W-1:0]        o_index_ff, o_index_in;

   logic                      r_ready, o_ready;
   logic signed [XY_W-1:0]    x_sum, y_sum;

   function automatic logic signed [OUT_W-1:0] neg_sat(
      input logic signed [ROUND_W-1:0] v,
      input logic                      negate
   );
      logic signed [ROUND_W:0] w;
      w = {v[ROUND_W-1], v};
      if (negate) begin
         w = -w;
      end
      if (w < (ROUND_W+1)'(OUT_MIN)) begin
         return OUT_MIN;
      end else if (w > (ROUND_W+1)'(OUT_MAX)) begin
         return OUT_MAX;
      end
      return w[OUT_W-1:0];
   endfunction

   assign r_ready  = !r_valid_ff || o_ready;
   assign o_ready  = !o_valid_ff || out_ready;
   assign in_ready = r_ready;

   assign x_sum = in_data.x + HALF;
   assign y_sum = in_data.y + HALF;

   always_comb begin
      r_valid_in = r_valid_ff;
      r_x_in     = r_x_ff;
      r_y_in     = r_y_ff;
      r_neg_in   = r_neg_ff;
      r_index_in = r_index_ff;
      if (r_ready) begin
         r_valid_in = in_valid;
      end
      if (r_ready && in_valid) begin
         r_x_in     = ROUND_W'(x_sum >>> 16);
         r_y_in     = ROUND_W'(y_sum >>> 16);
         r_neg_in   = in_data.negate;
         r_index_in = in_data.point_index;
      end
   end

   always_comb begin
      o_valid_in = o_valid_ff;
      o_x_in     = o_x_ff;
      o_y_in     = o_y_ff;
      o_index_in = o_index_ff;
      if (o_ready) begin
         o_valid_in = r_valid_ff;
      end
      if (o_ready && r_valid_ff) begin
         o_x_in     = neg_sat(r_x_ff, r_neg_ff);
         o_y_in     = neg_sat(r_y_ff, r_neg_ff);
         o_index_in = r_index_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         r_valid_ff <= r_valid_in;
         o_valid_ff <= o_valid_in;
      end
      r_x_ff     <= r_x_in;
      r_y_ff     <= r_y_in;
      r_neg_ff   <= r_neg_in;
      r_index_ff <= r_index_in;
      o_x_ff     <= o_x_in;
      o_y_ff     <= o_y_in;
      o_index_ff <= o_index_in;
   end

   assign out_valid   = o_valid_ff;
   assign x_position  = o_x_ff;
   assign y_position  = o_y_ff;
   assign point_index = o_index_ff;

endmodule

// ===== src/scan_polar_to_cartesian_unit.sv =====
`timescale 1ns / 1ps
// Laser reading to Cartesian point converter, top level.
// Pipeline: 2 front-end, 16 CORDIC and 2 finishing stages from an accepted
// reading to rsp valid. Throughput: one item per cycle while rsp is ready.
// Each stage has its own valid bit and ready, so bubbles close up under stall.
// Synchronous active-high reset empties the pipeline and clears both angle
// registers to 0. Depends on p2c_pkg, p2c_ifs and the p2c_* stage modules.
module scan_polar_to_cartesian_unit import p2c_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   p2c_req_if.sink    req_chan,
   p2c_rsp_if.source  rsp_chan,
   p2c_csr_if.sink    csr_chan
);

   // ---------------------------------------------------------------
   // Angle registers. Writes are always taken; the user must issue them only
   // with the pipeline empty (not enforced), so in-flight items see no change.
   // ---------------------------------------------------------------
   logic [ANGLE_W-1:0] start_angle_ff, start_angle_in;
   logic [ANGLE_W-1:0] angle_step_ff, angle_step_in;
   angle_cfg_type      cfg;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      start_angle_in = start_angle_ff;
      angle_step_in  = angle_step_ff;
      if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            CSR_START_ANGLE: start_angle_in = csr_chan.data;
            CSR_ANGLE_STEP:  angle_step_in  = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff <= '0;
         angle_step_ff  <= '0;
      end else begin
         start_angle_ff <= start_angle_in;
         angle_step_ff  <= angle_step_in;
      end
   end

   assign cfg.start_angle = start_angle_ff;
   assign cfg.angle_step  = angle_step_ff;

   // ---------------------------------------------------------------
   // Pipeline links: link 0 leaves the front end, link k leaves
   // CORDIC iteration k-1, the last link feeds the finishing stages.
   // ---------------------------------------------------------------
   logic       link_valid [CORDIC_STAGES+1];
   logic       link_ready [CORDIC_STAGES+1];
   cordic_type link_data  [CORDIC_STAGES+1];

   // front end: angle = start + index * step, fold to +/- quarter turn,
   // seed x with range * CORDIC gain compensation
   p2c_angle_prep u_prep (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .in_valid      (req_chan.valid),
      .in_ready      (req_chan.ready),
      .range_value   (req_chan.range_value),
      .no_return     (req_chan.no_return),
      .reading_index (req_chan.reading_index),
      .out_valid     (link_valid[0]),
      .out_ready     (link_ready[0]),
      .out_data      (link_data[0])
   );

   // one register stage per CORDIC iteration
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      p2c_cordic_stage #(
         .STAGE (g)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[g]),
         .in_ready  (link_ready[g]),
         .in_data   (link_data[g]),
         .out_valid (link_valid[g+1]),
         .out_ready (link_ready[g+1]),
         .out_data  (link_data[g+1])
      );
   end

   // round half up, undo the fold, saturate; last stage is the output register
   p2c_finish u_finish (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (link_valid[CORDIC_STAGES]),
      .in_ready    (link_ready[CORDIC_STAGES]),
      .in_data     (link_data[CORDIC_STAGES]),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .x_position  (rsp_chan.x_position),
      .y_position  (rsp_chan.y_position),
      .point_index (rsp_chan.point_index)
   );

endmodule

// ===== src/p2c_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for scan_polar_to_cartesian_unit, attached by bind.
// Depends on p2c_pkg and the top level.
module p2c_checker import p2c_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [OUT_W-1:0] rsp_x,
   input logic signed [OUT_W-1:0] rsp_y,
   input logic [INDEX_W-1:0]      rsp_index
);

   // reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // if the output can drain, the ready chain reaches the input
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled while output side can move");

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped under stall");

   // and keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(rsp_x) && $stable(rsp_y) && $stable(rsp_index)))
      else $error("result payload changed under stall");

endmodule

bind scan_polar_to_cartesian_unit p2c_checker u_p2c_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_x     (rsp_chan.x_position),
   .rsp_y     (rsp_chan.y_position),
   .rsp_index (rsp_chan.point_index)
);

// ===== bench/tb_scan_polar_to_cartesian_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for scan_polar_to_cartesian_unit: directed and random laser
// readings under several angle settings, every point checked in order against a
// local CORDIC predictor. Depends on p2c_pkg, p2c_ifs and the top level.
module tb_scan_polar_to_cartesian_unit;
   import p2c_pkg::*;

   localparam int  DRAIN_CYCLES = 32;      // exceeds the pipeline depth
   localparam int  LONG_HOLD    = 400;     // receiver hold-off, well past pipeline depth
   localparam int  CYCLE_LIMIT  = 400000;
   localparam longint GAIN      = 39797;   // CORDIC gain compensation, Q16

   // One predicted point, same widths as the result channel
   typedef struct {
      logic signed [OUT_W-1:0] x_position;
      logic signed [OUT_W-1:0] y_position;
      logic [INDEX_W-1:0]      point_index;
   } point_type;

   // Keeps a copy of the angle registers, predicts the point for every
   // accepted reading and checks results in arrival order.
   class point_checker;
      logic [ANGLE_W-1:0] start_angle;
      logic [ANGLE_W-1:0] angle_step;
      longint             atan_steps [CORDIC_STAGES];
      point_type          pending_points [$];
      int unsigned        readings, blanks, points, errors;

      function new();
         start_angle = '0;
         angle_step  = '0;
         atan_steps  = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                         652, 326, 163, 81, 41, 20, 10, 5};
         readings = 0;
         blanks   = 0;
         points   = 0;
         errors   = 0;
      endfunction

      function void set_angle(csr_index_type which, logic [ANGLE_W-1:0] value);
         if (which == CSR_START_ANGLE) start_angle = value;
         else angle_step = value;
      endfunction

      // round half up, undo the half-turn fold, clamp to the 17-bit range
      function logic signed [OUT_W-1:0] round_out(longint v, logic turned);
         longint r;
         r = (v + 32768) >>> 16;
         if (turned) r = -r;
         if (r < -65536) r = -65536;
         if (r > 65535) r = 65535;
         return r[OUT_W-1:0];
      endfunction

      function point_type rotate_reading(logic [RANGE_W-1:0] range_value,
                                         logic [INDEX_W-1:0] reading_index);
         logic [ANGLE_W-1:0] ang;
         logic               turned;
         longint             x, y, z, xs, ys;
         point_type          p;
         ang = start_angle + reading_index * angle_step;   // wraps mod one turn
         turned = (ang >= 16'd16384) && (ang < 16'd49152);
         if (turned) ang = ang + 16'd32768;
         z = longint'($signed(ang)) * 16;
         x = longint'(range_value) * GAIN;
         y = 0;
         for (int i = 0; i < CORDIC_STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x = x - ys;
               y = y + xs;
               z = z - atan_steps[i];
            end else begin
               x = x + ys;
               y = y - xs;
               z = z + atan_steps[i];
            end
         end
         p.x_position  = round_out(x, turned);
         p.y_position  = round_out(y, turned);
         p.point_index = reading_index;
         return p;
      endfunction

      function void note_reading(logic [RANGE_W-1:0] range_value, logic no_return,
                                 logic [INDEX_W-1:0] reading_index);
         readings++;
         if (no_return) blanks++;
         else pending_points.insert(pending_points.size(),
                                    rotate_reading(range_value, reading_index));
      endfunction

      function void check_point(logic signed [OUT_W-1:0] x_position,
                                logic signed [OUT_W-1:0] y_position,
                                logic [INDEX_W-1:0] point_index);
         point_type want;
         if (pending_points.size() == 0) begin
            $error("unexpected point: x %0d y %0d index %0d",
                   x_position, y_position, point_index);
            errors++;
            return;
         end
         want = pending_points.pop_front();
         points++;
         if (x_position !== want.x_position) begin
            $error("x_position mismatch: expected %0d, actual %0d",
                   want.x_position, x_position);
            errors++;
         end
         if (y_position !== want.y_position) begin
            $error("y_position mismatch: expected %0d, actual %0d",
                   want.y_position, y_position);
            errors++;
         end
         if (point_index !== want.point_index) begin
            $error("point_index mismatch: expected %0d, actual %0d",
                   want.point_index, point_index);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   int unsigned cycle_count = 0;
   int          hold_requests = 0;   // bumped by stimulus, served by the receiver
   int          settings_applied = 0;

   p2c_req_if req_bus ();
   p2c_rsp_if rsp_bus ();
   p2c_csr_if csr_bus ();

   point_checker point_sb = new();

   scan_polar_to_cartesian_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // 8 ns clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Monitors: all three channels sampled at the same edge the block sees.
   // Register copies update on the write edge; writes only happen when idle.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready)
            point_sb.set_angle(csr_bus.reg_index, csr_bus.data);
         if (req_bus.valid && req_bus.ready)
            point_sb.note_reading(req_bus.range_value, req_bus.no_return,
                                  req_bus.reading_index);
         if (rsp_bus.valid && rsp_bus.ready)
            point_sb.check_point(rsp_bus.x_position, rsp_bus.y_position,
                                 rsp_bus.point_index);
      end
   end

   // Receiver: segments of always-ready, coin-flip, mostly stalled and fully
   // stalled. A hold-off request drops ready while a LONG_HOLD countdown runs, so the
   // pipeline fills and backpressures the input.
   initial begin : receiver
      int hold_left;
      int seg_left;
      int seg_mode;
      int holds_served;
      hold_left    = 0;
      seg_left     = 0;
      seg_mode     = 0;
      holds_served = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_mode = $urandom_range(0, 3);
               seg_left = $urandom_range(8, 60);
            end
            seg_left--;
            case (seg_mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= 1'b0;
            endcase
         end
      end
   end

   // Drive one reading and hold it until accepted. Valid is left high so
   // back-to-back items never toggle it within one step.
   task automatic send_reading(logic [RANGE_W-1:0] range_value, logic no_return,
                               logic [INDEX_W-1:0] reading_index);
      req_bus.valid         <= 1'b1;
      req_bus.range_value   <= range_value;
      req_bus.no_return     <= no_return;
      req_bus.reading_index <= reading_index;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type which, logic [ANGLE_W-1:0] value);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= which;
      csr_bus.data      <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   // Let every pending point out, then cover no-return items still in flight
   task automatic wait_drained();
      while (point_sb.pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // New angle setting, applied only with the pipeline empty
   task automatic set_angles(logic [ANGLE_W-1:0] start_value, logic [ANGLE_W-1:0] step_value);
      req_bus.valid <= 1'b0;
      wait_drained();
      write_csr(CSR_START_ANGLE, start_value);
      write_csr(CSR_ANGLE_STEP, step_value);
      csr_bus.valid <= 1'b0;
      settings_applied++;
   endtask

   // Random scan traffic: mostly sequential indices like a real sweep, some
   // jumps; ranges mix full random with zero, full scale and short values.
   // With bursty clear the sender never gaps, used under the long hold-off.
   // Valid stays high after the last item; the caller drops it.
   task automatic run_scan(int count, bit bursty);
      int                 burst_left;
      int                 gap;
      int                 scan_len;
      logic [INDEX_W-1:0] idx;
      logic [RANGE_W-1:0] range_value;
      logic               no_return;
      burst_left = 0;
      idx        = '0;
      scan_len   = $urandom_range(16, 2048);
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = bursty ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         case ($urandom_range(0, 9))
            0:       range_value = '0;
            1:       range_value = '1;
            2:       range_value = RANGE_W'($urandom_range(0, 255));
            default: range_value = RANGE_W'($urandom());
         endcase
         no_return = ($urandom_range(0, 99) < 12);
         if ($urandom_range(0, 4) == 0) begin
            idx = INDEX_W'($urandom());
         end else begin
            idx = idx + 1'b1;
            if (idx >= scan_len) begin
               idx      = '0;
               scan_len = $urandom_range(16, 2048);
            end
         end
         send_reading(range_value, no_return, idx);
      end
   endtask

   initial begin : stimulus
      req_bus.valid         <= 1'b0;
      req_bus.range_value   <= '0;
      req_bus.no_return     <= 1'b0;
      req_bus.reading_index <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.reg_index     <= CSR_START_ANGLE;
      csr_bus.data          <= '0;
      reset                 <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // zero angle: zero range, full scale (x saturation), index extremes,
      // a no-return reading
      set_angles(16'd0, 16'd0);
      send_reading(16'd0, 1'b0, 11'd0);
      send_reading(16'hFFFF, 1'b0, 11'd0);
      send_reading(16'hFFFF, 1'b0, 11'd2047);
      send_reading(16'hFFFF, 1'b1, 11'd5);
      send_reading(16'd1, 1'b0, 11'd1);

      // quarter-turn fold boundary, going up
      set_angles(16'd16383, 16'd1);
      send_reading(16'hFFFF, 1'b0, 11'd0);
      send_reading(16'hFFFF, 1'b0, 11'd1);
      send_reading(16'd40000, 1'b1, 11'd2);
      send_reading(16'hFFFF, 1'b0, 11'd2047);

      // three-quarter boundary, going down
      set_angles(16'hC000, 16'hFFFF);
      send_reading(16'hFFFF, 1'b0, 11'd0);
      send_reading(16'hFFFF, 1'b0, 11'd1);

      // half-turn, signed wrap of the residual
      set_angles(16'h7FFF, 16'd1);
      send_reading(16'hFFFF, 1'b0, 11'd0);
      send_reading(16'hFFFF, 1'b0, 11'd1);
      send_reading(16'd12345, 1'b0, 11'd2);

      // register extremes, index product wrapping mod one turn
      set_angles(16'h8000, 16'h7FFF);
      send_reading(16'hFFFF, 1'b0, 11'd2047);
      send_reading(16'd0, 1'b0, 11'd2047);
      send_reading(16'hFFFF, 1'b0, 11'd1024);

      // random phases; sender drains fully before each new setting
      set_angles(16'($urandom()), 16'd32);
      run_scan(200, 1'b1);
      set_angles(16'h8000, 16'h7FFF);
      run_scan(200, 1'b1);
      set_angles(16'h7FFF, 16'h8000);
      run_scan(200, 1'b1);

      // long receiver hold-off with a gapless sender: pipeline fills,
      // input must stall and recover without losing items
      set_angles(16'($urandom()), 16'($urandom()));
      hold_requests <= hold_requests + 1;
      run_scan(250, 1'b0);

      set_angles(16'h0000, 16'hFFFF);
      run_scan(200, 1'b1);
      set_angles(16'($urandom()), 16'($urandom()));
      run_scan(200, 1'b1);

      req_bus.valid <= 1'b0;
      wait_drained();

      $display("Covered %0d readings (%0d no-return) over %0d angle settings, %0d points",
               point_sb.readings, point_sb.blanks, settings_applied, point_sb.points);
      $display("including fold boundaries, full-scale ranges and a %0d-cycle output stall",
               LONG_HOLD);
      if (point_sb.errors == 0 && point_sb.pending_points.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
